### rtl/core/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants of the rgb fade sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfs_pkg;

    typedef logic [7:0]  level_t;
    typedef logic [6:0]  pos_t;
    typedef logic [15:0] interval_t;
    typedef logic [31:0] time_t;

    localparam pos_t      POS_FULL       = 7'd100;
    localparam pos_t      ROUND_UP       = 7'd99;
    localparam int        RECIP_SHIFT    = 19;
    localparam logic [12:0] RECIP_MUL    = 13'd5243;
    localparam interval_t INTERVAL_RESET = 16'd10;

    localparam int        CFG_INDEX_W    = 3;
    localparam int        CFG_DATA_W     = 16;

    typedef enum logic [1:0] {
        FUNC_UPDATE    = 2'd0,
        FUNC_TURN_ON   = 2'd1,
        FUNC_TURN_OFF  = 2'd2,
        FUNC_FORCE_OFF = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED_START     = 3'd0,
        CFG_RED_END       = 3'd1,
        CFG_GREEN_START   = 3'd2,
        CFG_GREEN_END     = 3'd3,
        CFG_BLUE_START    = 3'd4,
        CFG_BLUE_END      = 3'd5,
        CFG_STEP_INTERVAL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] func;
        time_t      now_ms;
    } in_t;

    typedef struct packed {
        logic   pixel_write;
        level_t red;
        level_t green;
        level_t blue;
        logic   fading_up;
        logic   fading_down;
        logic   reached_on;
        logic   reached_off;
        pos_t   fade_position;
    } out_t;

    typedef struct packed {
        logic pixel_write;
        logic fading_up;
        logic fading_down;
        logic reached_on;
        logic reached_off;
        pos_t fade_position;
    } status_t;

    typedef struct packed {
        logic    colour_en;
        pos_t    pos;
        status_t status;
    } ctrl_t;

endpackage

`default_nettype wire

### rtl/core/rfs_ctrl.sv
// ----------------------------------------------------------------------------
// rfs_ctrl
// Fade state, command decode and step timing for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module rfs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire rfs_pkg::in_t       in_data,
    input  wire rfs_pkg::interval_t step_interval,
    output rfs_pkg::ctrl_t          ctrl
);
    import rfs_pkg::*;

    pos_t  step_reg, step_next;
    logic  up_reg, up_next;
    logic  dn_reg, dn_next;
    logic  on_reg, on_next;
    logic  off_reg, off_next;
    time_t last_reg, last_next;
    time_t elapsed;
    logic  due;
    logic  wr;
    logic  colour_en;

    assign elapsed = in_data.now_ms - last_reg;
    assign due     = elapsed >= {16'd0, step_interval};

    always_comb begin
        step_next = step_reg;
        up_next   = up_reg;
        dn_next   = dn_reg;
        on_next   = on_reg;
        off_next  = off_reg;
        last_next = last_reg;
        wr        = 1'b0;
        colour_en = 1'b0;
        unique case (func_t'(in_data.func))
            FUNC_TURN_ON: begin
                up_next = 1'b1;
                dn_next = 1'b0;
            end
            FUNC_TURN_OFF: begin
                up_next = 1'b0;
                dn_next = 1'b1;
            end
            FUNC_FORCE_OFF: begin
                up_next = 1'b0;
                dn_next = 1'b1;
                wr      = 1'b1;
            end
            default: begin
                if (up_reg && step_reg == POS_FULL) begin
                    on_next = 1'b1;
                    up_next = 1'b0;
                end
                if (dn_reg && step_reg == 7'd0) begin
                    dn_next  = 1'b0;
                    off_next = 1'b1;
                    wr       = 1'b1;
                end
                if ((up_next || dn_next) && due) begin
                    colour_en = 1'b1;
                    wr        = 1'b1;
                    last_next = in_data.now_ms;
                    step_next = up_next ? step_reg + 7'd1 : step_reg - 7'd1;
                end
            end
        endcase
    end

    always_comb begin
        ctrl.colour_en                = colour_en;
        ctrl.pos                      = (step_reg > POS_FULL) ? POS_FULL : step_reg;
        ctrl.status.pixel_write       = wr;
        ctrl.status.fading_up         = up_next;
        ctrl.status.fading_down       = dn_next;
        ctrl.status.reached_on        = on_next;
        ctrl.status.reached_off       = off_next;
        ctrl.status.fade_position     = step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            up_reg   <= 1'b0;
            dn_reg   <= 1'b0;
            on_reg   <= 1'b0;
            off_reg  <= 1'b1;
            last_reg <= '0;
        end else if (accept) begin
            step_reg <= step_next;
            up_reg   <= up_next;
            dn_reg   <= dn_next;
            on_reg   <= on_next;
            off_reg  <= off_next;
            last_reg <= last_next;
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= POS_FULL)
        else $error("fade position out of range");

    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        !(up_reg && dn_reg))
        else $error("fade up and fade down both active");

    a_on_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        on_reg |=> on_reg)
        else $error("reached-on flag cleared");

endmodule

`default_nettype wire

### rtl/core/rfs_blend.sv
// ----------------------------------------------------------------------------
// rfs_blend
// Two-stage channel blend, start + (end - start) * pos / 100, zero if !colour_en.
// ----------------------------------------------------------------------------
`default_nettype none

module rfs_blend (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire rfs_pkg::level_t level_start,
    input  wire rfs_pkg::level_t level_end,
    input  wire rfs_pkg::pos_t   pos,
    input  wire logic            colour_en,
    output rfs_pkg::level_t      level
);
    import rfs_pkg::*;

    localparam int PROD_W  = 15;
    localparam int SCALE_W = PROD_W + 13;

    logic                neg;
    level_t              diff;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   x_next, x_reg;
    logic                neg_reg;
    level_t              start_reg;
    logic                colour_en_reg;
    logic [SCALE_W-1:0]  scaled;
    level_t              quot;
    level_t              level_next, level_reg;

    // downward blends round the step up so the result is a true floor
    assign neg    = level_end < level_start;
    assign diff   = neg ? level_start - level_end : level_end - level_start;
    assign prod   = PROD_W'(diff) * PROD_W'(pos);
    assign x_next = prod + (neg ? PROD_W'(ROUND_UP) : PROD_W'(0));

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg         <= x_next;
            neg_reg       <= neg;
            start_reg     <= level_start;
            colour_en_reg <= colour_en;
        end
    end

    // divide by one hundred through the reciprocal
    assign scaled = SCALE_W'(x_reg) * SCALE_W'(RECIP_MUL);
    assign quot   = scaled[RECIP_SHIFT +: 8];

    always_comb begin
        if (!colour_en_reg) begin
            level_next = '0;
        end else if (neg_reg) begin
            level_next = start_reg - quot;
        end else begin
            level_next = start_reg + quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

### rtl/core/rgb_fade_sequencer.sv
// ----------------------------------------------------------------------------
// rgb_fade_sequencer
// Linear RGB colour fade of one pixel over one hundred timed steps.
// ----------------------------------------------------------------------------
// pipeline: two register stages, a request is held in the stage register and then
// in the result register
// throughput: one request per cycle unless halted, set by the state update
// the pipeline halts only while the result register is full and not taken
// reset (synchronous, active low): fade state cleared, reached-off set,
// colour start and end registers zero, step interval ten, pipeline empty, no request taken
`default_nettype none

module rgb_fade_sequencer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire rfs_pkg::in_t                        s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output rfs_pkg::out_t                            m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rfs_pkg::*;

    level_t    red_start_reg, red_end_reg;
    level_t    green_start_reg, green_end_reg;
    level_t    blue_start_reg, blue_end_reg;
    interval_t interval_reg;

    logic      adv;
    logic      accept;
    ctrl_t     ctrl;
    logic      v1_reg;
    logic      m_valid_reg;
    status_t   status1_reg, status2_reg;
    level_t    red, green, blue;

    assign cfg_ready = aresetn;
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv && aresetn;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_start_reg   <= '0;
            red_end_reg     <= '0;
            green_start_reg <= '0;
            green_end_reg   <= '0;
            blue_start_reg  <= '0;
            blue_end_reg    <= '0;
            interval_reg    <= INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RED_START:     red_start_reg   <= cfg_data[7:0];
                CFG_RED_END:       red_end_reg     <= cfg_data[7:0];
                CFG_GREEN_START:   green_start_reg <= cfg_data[7:0];
                CFG_GREEN_END:     green_end_reg   <= cfg_data[7:0];
                CFG_BLUE_START:    blue_start_reg  <= cfg_data[7:0];
                CFG_BLUE_END:      blue_end_reg    <= cfg_data[7:0];
                CFG_STEP_INTERVAL: interval_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    rfs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_data       (s_data),
        .step_interval (interval_reg),
        .ctrl          (ctrl)
    );

    rfs_blend u_blend_red (
        .aclk        (aclk),
        .en          (adv),
        .level_start (red_start_reg),
        .level_end   (red_end_reg),
        .pos         (ctrl.pos),
        .colour_en   (ctrl.colour_en),
        .level       (red)
    );

    rfs_blend u_blend_green (
        .aclk        (aclk),
        .en          (adv),
        .level_start (green_start_reg),
        .level_end   (green_end_reg),
        .pos         (ctrl.pos),
        .colour_en   (ctrl.colour_en),
        .level       (green)
    );

    rfs_blend u_blend_blue (
        .aclk        (aclk),
        .en          (adv),
        .level_start (blue_start_reg),
        .level_end   (blue_end_reg),
        .pos         (ctrl.pos),
        .colour_en   (ctrl.colour_en),
        .level       (blue)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= accept;
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status1_reg <= ctrl.status;
            status2_reg <= status1_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        m_data.pixel_write   = status2_reg.pixel_write;
        m_data.red           = red;
        m_data.green         = green;
        m_data.blue          = blue;
        m_data.fading_up     = status2_reg.fading_up;
        m_data.fading_down   = status2_reg.fading_down;
        m_data.reached_on    = status2_reg.reached_on;
        m_data.reached_off   = status2_reg.reached_off;
        m_data.fade_position = status2_reg.fade_position;
    end

    a_black_without_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pixel_write) |->
            (m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("colour present on a result without pixel write");

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v1_reg))
        else $error("result valid without a request in flight");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv) |=> v1_reg)
        else $error("request lost in a stalled pipeline");

endmodule

`default_nettype wire
